/* rtl/core/scim_pkg.sv */
package scim_pkg;

  localparam int SLOTS = 8;
  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [2:0] ACT_ACQUIRE = 3'd0;
  localparam logic [2:0] ACT_PRESENT = 3'd1;
  localparam logic [2:0] ACT_RETIRE = 3'd2;
  localparam logic [2:0] ACT_SET_OCC = 3'd3;
  localparam logic [2:0] ACT_SET_LOST = 3'd4;
  localparam logic [2:0] ACT_MARK_OOD = 3'd5;
  localparam logic [2:0] ACT_RECREATE = 3'd6;
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  localparam logic [3:0] ST_ACQUIRED = 4'd0;
  localparam logic [3:0] ST_NOT_READY = 4'd1;
  localparam logic [3:0] ST_OUT_OF_DATE = 4'd2;
  localparam logic [3:0] ST_OCCLUDED = 4'd3;
  localparam logic [3:0] ST_LOST = 4'd4;
  localparam logic [3:0] ST_PRESENTED = 4'd5;
  localparam logic [3:0] ST_SKIPPED = 4'd6;
  localparam logic [3:0] ST_RETIRED = 4'd7;
  localparam logic [3:0] ST_STALE = 4'd8;
  localparam logic [3:0] ST_BACKPRESSURE = 4'd9;
  localparam logic [3:0] ST_BUDGET = 4'd10;
  localparam logic [3:0] ST_REGRESSION = 4'd11;
  localparam logic [3:0] ST_INVALID = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  localparam logic [2:0] REG_IMAGE_COUNT = 3'd0;
  localparam logic [2:0] REG_MAX_FLIGHT = 3'd1;
  localparam logic [2:0] REG_MAX_DAMAGE = 3'd2;
  localparam logic [2:0] REG_BYTES_PER_IMAGE = 3'd3;
  localparam logic [2:0] REG_BYTE_BUDGET = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RETIRE,
    S_PRESENT,
    S_OUT
  } state_t;

endpackage

/* rtl/core/swapchain_image_slot_manager.sv */
// Swapchain image slot manager. One item in, one result out, on valid/ready
// channels. Present, flag and recreate actions and refused items go from
// decode straight to the result. Acquire scans one slot per cycle, up to
// SLOTS slots, after first folding the round-robin pointer back into range
// if image_count has shrunk. Retire walks every slot through a single
// compare unit, one per cycle.
// in_ready is low while an item is in work or its result waits.
// Registers are written over the cfg_ APB port, at byte address 4*index.
module swapchain_image_slot_manager (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_slot_index,
  input  logic [31:0] in_image_serial,
  input  logic [7:0]  in_damage_count,
  input  logic        in_full_redraw,
  input  logic [31:0] in_completed_fence,
  input  logic        in_flag_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [3:0]  out_slot_out,
  output logic [31:0] out_serial_out,
  output logic [31:0] out_fence_out,
  output logic [3:0]  out_owned_count,
  output logic [3:0]  out_flight_count,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SW = scim_pkg::SW;
  localparam int CW = scim_pkg::CW;
  localparam int SLOTS = scim_pkg::SLOTS;

  logic [3:0]  image_count_r;
  logic [3:0]  max_flight_r;
  logic [6:0]  max_damage_r;
  logic [30:0] bytes_per_image_r;
  logic [31:0] byte_budget_r;

  logic [SLOTS-1:0] owned_r, busy_r;
  logic [31:0] fence_mem_r [SLOTS];
  logic [31:0] serial_mem_r [SLOTS];
  logic [SW-1:0] next_slot_r;
  logic [CW-1:0] owned_total_r, flight_total_r;
  logic [31:0] flight_bytes_r, next_serial_r, next_fence_r;
  logic [31:0] last_sub_r, last_comp_r;
  logic [2:0]  sticky_r;

  scim_pkg::state_t state_r;
  scim_pkg::state_t state_nxt;

  logic [2:0]  act_r;
  logic [3:0]  idx_r;
  logic [31:0] ser_r;
  logic [7:0]  dmg_r;
  logic        full_r;
  logic [31:0] done_r;
  logic        flag_r;

  logic [SW-1:0] cur_r;
  logic [SW:0]   cnt_r;
  logic [SW:0]   live;

  logic [3:0]  st_r;
  logic [3:0]  slot_o_r;
  logic [31:0] serial_o_r;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[4:2];

  always_comb begin
    case (cfg_idx)
      scim_pkg::REG_IMAGE_COUNT:     cfg_prdata = {28'd0, image_count_r};
      scim_pkg::REG_MAX_FLIGHT:      cfg_prdata = {28'd0, max_flight_r};
      scim_pkg::REG_MAX_DAMAGE:      cfg_prdata = {25'd0, max_damage_r};
      scim_pkg::REG_BYTES_PER_IMAGE: cfg_prdata = {1'b0, bytes_per_image_r};
      scim_pkg::REG_BYTE_BUDGET:     cfg_prdata = byte_budget_r;
      default:                       cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_count_r <= 4'd3;
      max_flight_r <= 4'd2;
      max_damage_r <= 7'd32;
      bytes_per_image_r <= 31'd4194304;
      byte_budget_r <= 32'd134217728;
    end else if (cfg_wr) begin
      case (cfg_idx)
        scim_pkg::REG_IMAGE_COUNT:     image_count_r <= cfg_pwdata[3:0];
        scim_pkg::REG_MAX_FLIGHT:      max_flight_r <= cfg_pwdata[3:0];
        scim_pkg::REG_MAX_DAMAGE:      max_damage_r <= cfg_pwdata[6:0];
        scim_pkg::REG_BYTES_PER_IMAGE: bytes_per_image_r <= cfg_pwdata[30:0];
        scim_pkg::REG_BYTE_BUDGET:     byte_budget_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  assign live = ({1'b0, image_count_r} < 5'(SLOTS)) ? (SW+1)'(image_count_r)
                                                    : (SW+1)'(SLOTS);

  assign in_ready = (state_r == scim_pkg::S_IDLE);
  assign out_valid = (state_r == scim_pkg::S_OUT);
  assign out_status = st_r;
  assign out_slot_out = slot_o_r;
  assign out_serial_out = serial_o_r;
  assign out_fence_out = last_sub_r;
  assign out_owned_count = 4'(owned_total_r);
  assign out_flight_count = 4'(flight_total_r);

  // shared per-slot unit
  logic        cur_free, cur_cover;
  logic [SW-1:0] cur_wrap;
  logic [32:0] bytes_sum;
  logic        idx_live;
  logic [SW-1:0] idx_s;
  assign cur_free = !owned_r[cur_r] && !busy_r[cur_r];
  assign cur_cover = busy_r[cur_r] && (fence_mem_r[cur_r] <= done_r);
  assign cur_wrap = ({1'b0, cur_r} + 1'b1 >= live) ? '0 : cur_r + 1'b1;
  assign bytes_sum = {1'b0, flight_bytes_r} + {2'b0, bytes_per_image_r};
  assign idx_live = {1'b0, idx_r} < 5'(live);
  assign idx_s = idx_r[SW-1:0];

  logic [2:0] stk;
  logic [3:0] stk_st;
  always_comb begin
    stk = sticky_r;
    if (stk[2]) stk_st = scim_pkg::ST_LOST;
    else if (stk[0]) stk_st = scim_pkg::ST_OUT_OF_DATE;
    else if (stk[1]) stk_st = scim_pkg::ST_OCCLUDED;
    else stk_st = scim_pkg::ST_DONE;
  end

  logic acq_go, ret_go;
  assign acq_go = (act_r == scim_pkg::ACT_ACQUIRE) && (stk_st == scim_pkg::ST_DONE)
                  && (5'(owned_total_r) + 5'(flight_total_r) < 5'(max_flight_r))
                  && (live != '0);
  assign ret_go = (act_r == scim_pkg::ACT_RETIRE) && !(done_r < last_comp_r)
                  && !(done_r > last_sub_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scim_pkg::S_IDLE: begin
        if (in_valid) state_nxt = scim_pkg::S_PRESENT;
      end
      scim_pkg::S_PRESENT: begin
        if (acq_go) state_nxt = scim_pkg::S_SCAN;
        else if (ret_go) state_nxt = scim_pkg::S_RETIRE;
        else state_nxt = scim_pkg::S_OUT;
      end
      scim_pkg::S_SCAN: begin
        if ({1'b0, cur_r} < live && (cur_free || cnt_r + 1'b1 >= live))
          state_nxt = scim_pkg::S_OUT;
      end
      scim_pkg::S_RETIRE: begin
        if (32'(cur_r) == 32'(SLOTS - 1)) state_nxt = scim_pkg::S_OUT;
      end
      scim_pkg::S_OUT: begin
        if (out_ready) state_nxt = scim_pkg::S_IDLE;
      end
      default: state_nxt = scim_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= scim_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owned_r <= '0;
      busy_r <= '0;
      next_slot_r <= '0;
      owned_total_r <= '0;
      flight_total_r <= '0;
      flight_bytes_r <= '0;
      next_serial_r <= 32'd1;
      next_fence_r <= 32'd1;
      last_sub_r <= '0;
      last_comp_r <= '0;
      sticky_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        fence_mem_r[i] <= '0;
        serial_mem_r[i] <= '0;
      end
    end else begin
      case (state_r)
        scim_pkg::S_IDLE: begin
          if (in_valid) begin
            act_r <= in_action;
            idx_r <= in_slot_index;
            ser_r <= in_image_serial;
            dmg_r <= in_damage_count;
            full_r <= in_full_redraw;
            done_r <= in_completed_fence;
            flag_r <= in_flag_value;
          end
        end
        scim_pkg::S_PRESENT: begin
          // decode, and the actions that are done in full in this state
          slot_o_r <= (act_r == scim_pkg::ACT_PRESENT) ? idx_r : '0;
          serial_o_r <= (act_r == scim_pkg::ACT_PRESENT) ? ser_r : '0;
          case (act_r)
            scim_pkg::ACT_ACQUIRE: begin
              if (stk_st != scim_pkg::ST_DONE) st_r <= stk_st;
              else begin
                st_r <= scim_pkg::ST_NOT_READY;
                cur_r <= next_slot_r;
                cnt_r <= '0;
              end
            end
            scim_pkg::ACT_PRESENT: begin
              if (!idx_live) st_r <= scim_pkg::ST_INVALID;
              else if (!owned_r[idx_s] || serial_mem_r[idx_s] != ser_r)
                st_r <= scim_pkg::ST_STALE;
              else if ({1'b0, dmg_r} > {2'b0, max_damage_r})
                st_r <= scim_pkg::ST_BUDGET;
              else if (dmg_r == 8'd0 && !full_r) begin
                owned_r[idx_s] <= 1'b0;
                owned_total_r <= owned_total_r - 1'b1;
                st_r <= scim_pkg::ST_SKIPPED;
              end else if (5'(flight_total_r) >= 5'(max_flight_r))
                st_r <= scim_pkg::ST_BACKPRESSURE;
              else if (stk_st != scim_pkg::ST_DONE) begin
                owned_r[idx_s] <= 1'b0;
                owned_total_r <= owned_total_r - 1'b1;
                st_r <= stk_st;
              end else if (bytes_sum > {1'b0, byte_budget_r})
                st_r <= scim_pkg::ST_BUDGET;
              else if (next_fence_r == 32'hFFFF_FFFF)
                st_r <= scim_pkg::ST_BACKPRESSURE;
              else begin
                fence_mem_r[idx_s] <= next_fence_r;
                last_sub_r <= next_fence_r;
                next_fence_r <= next_fence_r + 1'b1;
                owned_r[idx_s] <= 1'b0;
                owned_total_r <= owned_total_r - 1'b1;
                busy_r[idx_s] <= 1'b1;
                flight_total_r <= flight_total_r + 1'b1;
                flight_bytes_r <= bytes_sum[31:0];
                st_r <= scim_pkg::ST_PRESENTED;
              end
            end
            scim_pkg::ACT_RETIRE: begin
              if (done_r < last_comp_r || done_r > last_sub_r)
                st_r <= scim_pkg::ST_REGRESSION;
              else begin
                st_r <= scim_pkg::ST_RETIRED;
                last_comp_r <= done_r;
                cur_r <= '0;
              end
            end
            scim_pkg::ACT_SET_OCC: begin
              sticky_r[1] <= flag_r;
              st_r <= scim_pkg::ST_DONE;
            end
            scim_pkg::ACT_SET_LOST: begin
              sticky_r[2] <= flag_r;
              st_r <= scim_pkg::ST_DONE;
            end
            scim_pkg::ACT_MARK_OOD: begin
              sticky_r[0] <= 1'b1;
              st_r <= scim_pkg::ST_DONE;
            end
            scim_pkg::ACT_RECREATE: begin
              if (!sticky_r[0]) st_r <= scim_pkg::ST_INVALID;
              else if (owned_total_r != '0 || flight_total_r != '0)
                st_r <= scim_pkg::ST_BACKPRESSURE;
              else begin
                owned_r <= '0;
                busy_r <= '0;
                next_slot_r <= '0;
                flight_bytes_r <= '0;
                sticky_r <= '0;
                for (int i = 0; i < SLOTS; i++) begin
                  fence_mem_r[i] <= '0;
                  serial_mem_r[i] <= '0;
                end
                st_r <= scim_pkg::ST_DONE;
              end
            end
            default: st_r <= scim_pkg::ST_INVALID;
          endcase
        end
        scim_pkg::S_SCAN: begin
          // pointer left past the ring by a smaller image count: fold it back
          if ({1'b0, cur_r} >= live) cur_r <= cur_r - live[SW-1:0];
          else if (cur_free) begin
            owned_r[cur_r] <= 1'b1;
            serial_mem_r[cur_r] <= next_serial_r;
            next_serial_r <= next_serial_r + 1'b1;
            owned_total_r <= owned_total_r + 1'b1;
            next_slot_r <= cur_wrap;
            slot_o_r <= 4'(cur_r);
            serial_o_r <= next_serial_r;
            st_r <= scim_pkg::ST_ACQUIRED;
          end else if (cnt_r + 1'b1 < live) begin
            cur_r <= cur_wrap;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        scim_pkg::S_RETIRE: begin
          if (cur_cover) begin
            busy_r[cur_r] <= 1'b0;
            fence_mem_r[cur_r] <= '0;
            flight_total_r <= flight_total_r - 1'b1;
            flight_bytes_r <= (flight_bytes_r > {1'b0, bytes_per_image_r})
                              ? flight_bytes_r - {1'b0, bytes_per_image_r} : '0;
          end
          if (32'(cur_r) != 32'(SLOTS - 1)) cur_r <= cur_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(owned_r) == 32'(owned_total_r))
    else $error("owned total mismatch");
  a_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(busy_r) == 32'(flight_total_r))
    else $error("flight total mismatch");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (owned_r & busy_r) == '0)
    else $error("slot both owned and busy");
  a_fence: assert property (@(posedge clk) disable iff (!rst_n)
    last_comp_r <= last_sub_r)
    else $error("completed beyond submitted");

endmodule

/* sim/swapchain_image_slot_manager_checker.sv */
`timescale 1ns / 1ps

module swapchain_image_slot_manager_checker
  import scim_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_slot_index,
  input  logic [31:0] in_image_serial,
  input  logic [7:0]  in_damage_count,
  input  logic        in_full_redraw,
  input  logic [31:0] in_completed_fence,
  input  logic        in_flag_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_status,
  input  logic [3:0]  out_slot_out,
  input  logic [31:0] out_serial_out,
  input  logic [31:0] out_fence_out,
  input  logic [3:0]  out_owned_count,
  input  logic [3:0]  out_flight_count,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [3:0]  status;
    logic [3:0]  slot;
    logic [31:0] serial;
    logic [31:0] fence;
    logic [3:0]  owned;
    logic [3:0]  flight;
  } frame_result_t;

  frame_result_t expected_q[$];

  logic [3:0]  r_images, r_max_flight;
  logic [6:0]  r_max_damage;
  logic [30:0] r_bytes_per_image;
  logic [31:0] r_budget;

  logic        owned_v[SLOTS];
  logic        busy_v[SLOTS];
  logic [31:0] fence_v[SLOTS];
  logic [31:0] serial_v[SLOTS];
  int          ring_ptr, owned_n, flight_n;
  logic [31:0] bytes_out, serial_ctr, fence_ctr, submitted, completed;
  logic        c_ood, c_occ, c_lost;

  task automatic clear_ring();
    for (int i = 0; i < SLOTS; i++) begin
      owned_v[i] = 0;
      busy_v[i] = 0;
      fence_v[i] = 0;
      serial_v[i] = 0;
    end
    ring_ptr = 0;
    owned_n = 0;
    flight_n = 0;
    bytes_out = 0;
  endtask

  task automatic drop_owned(input int idx);
    owned_v[idx] = 0;
    if (owned_n > 0) owned_n--;
  endtask

  function automatic logic [3:0] sticky_code();
    if (c_lost) return ST_LOST;
    if (c_ood) return ST_OUT_OF_DATE;
    if (c_occ) return ST_OCCLUDED;
    return ST_DONE;
  endfunction

  task automatic predict_frame(output frame_result_t r);
    int n, idx;
    logic found;
    logic [3:0] st;
    r = '0;
    n = (r_images < SLOTS) ? int'(r_images) : SLOTS;
    r.fence = 'x;
    case (in_action)
      ACT_ACQUIRE: begin
        st = sticky_code();
        if (st != ST_DONE) r.status = st;
        else if (owned_n + flight_n >= r_max_flight || n == 0) r.status = ST_NOT_READY;
        else begin
          found = 0;
          r.status = ST_NOT_READY;
          for (int off = 0; off < n; off++) begin
            idx = (ring_ptr + off) % n;
            if (!found && !owned_v[idx] && !busy_v[idx]) begin
              found = 1;
              ring_ptr = (idx + 1) % n;
              owned_v[idx] = 1;
              serial_v[idx] = serial_ctr;
              serial_ctr = serial_ctr + 1;
              owned_n++;
              r.slot = 4'(idx);
              r.serial = serial_v[idx];
              r.status = ST_ACQUIRED;
            end
          end
        end
      end
      ACT_PRESENT: begin
        idx = in_slot_index;
        r.slot = in_slot_index;
        r.serial = in_image_serial;
        if (idx >= n) r.status = ST_INVALID;
        else if (!owned_v[idx] || serial_v[idx] != in_image_serial) r.status = ST_STALE;
        else if (in_damage_count > r_max_damage) r.status = ST_BUDGET;
        else if (in_damage_count == 0 && !in_full_redraw) begin
          drop_owned(idx);
          r.status = ST_SKIPPED;
        end else if (flight_n >= r_max_flight) r.status = ST_BACKPRESSURE;
        else if (sticky_code() != ST_DONE) begin
          drop_owned(idx);
          r.status = sticky_code();
        end else if ({1'b0, bytes_out} + {2'b0, r_bytes_per_image} > {1'b0, r_budget})
          r.status = ST_BUDGET;
        else if (fence_ctr == 32'hFFFF_FFFF) r.status = ST_BACKPRESSURE;
        else begin
          fence_v[idx] = fence_ctr;
          submitted = fence_ctr;
          fence_ctr = fence_ctr + 1;
          drop_owned(idx);
          busy_v[idx] = 1;
          flight_n++;
          bytes_out = bytes_out + r_bytes_per_image;
          r.fence = submitted;
          r.status = ST_PRESENTED;
        end
      end
      ACT_RETIRE: begin
        if (in_completed_fence < completed || in_completed_fence > submitted)
          r.status = ST_REGRESSION;
        else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (busy_v[i] && fence_v[i] <= in_completed_fence) begin
              busy_v[i] = 0;
              fence_v[i] = 0;
              if (flight_n > 0) flight_n--;
              bytes_out = (bytes_out > r_bytes_per_image) ? bytes_out - r_bytes_per_image : 0;
            end
          end
          completed = in_completed_fence;
          r.status = ST_RETIRED;
        end
      end
      ACT_SET_OCC: begin
        c_occ = in_flag_value;
        r.status = ST_DONE;
      end
      ACT_SET_LOST: begin
        c_lost = in_flag_value;
        r.status = ST_DONE;
      end
      ACT_MARK_OOD: begin
        c_ood = 1;
        r.status = ST_DONE;
      end
      ACT_RECREATE: begin
        if (!c_ood) r.status = ST_INVALID;
        else if (owned_n != 0 || flight_n != 0) r.status = ST_BACKPRESSURE;
        else begin
          clear_ring();
          c_ood = 0;
          c_occ = 0;
          c_lost = 0;
          r.status = ST_DONE;
        end
      end
      default: r.status = ST_INVALID;
    endcase
    if (r.status != ST_PRESENTED) r.fence = submitted;
    r.owned = owned_n[3:0];
    r.flight = flight_n[3:0];
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    frame_result_t e, a;
    if (!rst_n) begin
      r_images = 3;
      r_max_flight = 2;
      r_max_damage = 32;
      r_bytes_per_image = 31'd4194304;
      r_budget = 32'd134217728;
      clear_ring();
      serial_ctr = 1;
      fence_ctr = 1;
      submitted = 0;
      completed = 0;
      c_ood = 0;
      c_occ = 0;
      c_lost = 0;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_IMAGE_COUNT: r_images = cfg_pwdata[3:0];
          REG_MAX_FLIGHT: r_max_flight = cfg_pwdata[3:0];
          REG_MAX_DAMAGE: r_max_damage = cfg_pwdata[6:0];
          REG_BYTES_PER_IMAGE: r_bytes_per_image = cfg_pwdata[30:0];
          REG_BYTE_BUDGET: r_budget = cfg_pwdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_frame(e);
        expected_q.push_back(e);
      end
      if (out_valid && out_ready) begin
        a = '{out_status, out_slot_out, out_serial_out, out_fence_out,
              out_owned_count, out_flight_count};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: unexpected result %h", $time, a);
        end else begin
          e = expected_q.pop_front();
          if (a !== e) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: expected st=%0d slot=%0d ser=%h fence=%h own=%0d fl=%0d",
                       $time, e.status, e.slot, e.serial, e.fence, e.owned, e.flight);
              $display("%0t:      got st=%0d slot=%0d ser=%h fence=%h own=%0d fl=%0d",
                       $time, a.status, a.slot, a.serial, a.fence, a.owned, a.flight);
            end
          end
        end
      end
    end
  end

endmodule

/* sim/swapchain_image_slot_manager_tb.sv */
`timescale 1ns / 1ps

module swapchain_image_slot_manager_tb;
  import scim_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_action = 0;
  logic [3:0]  in_slot_index = 0;
  logic [31:0] in_image_serial = 0;
  logic [7:0]  in_damage_count = 0;
  logic        in_full_redraw = 0;
  logic [31:0] in_completed_fence = 0;
  logic        in_flag_value = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [3:0]  out_status, out_slot_out, out_owned_count, out_flight_count;
  logic [31:0] out_serial_out, out_fence_out;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [4:0]  cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          mismatches, pending;

  swapchain_image_slot_manager u_top (.*);
  swapchain_image_slot_manager_checker u_chk (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  logic        quiet = 0;
  int          stall_left = 0;
  int          items_sent = 0, frames_shown = 0, retires_done = 0, settings_run = 0;
  int          idle_cycles = 0;
  logic [3:0]  ticket_slot[$];
  logic [31:0] ticket_serial[$];
  logic [31:0] top_fence = 0, retire_floor = 0, retire_req = 0;

  always @(posedge clk) begin
    if (!rst_n || quiet) out_ready <= 1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else if ($urandom_range(7) == 0) begin
      stall_left <= $urandom_range(1, 10) - 1;
      out_ready <= 0;
    end else out_ready <= 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      case (out_status)
        ST_ACQUIRED: begin
          ticket_slot.push_back(out_slot_out);
          ticket_serial.push_back(out_serial_out);
        end
        ST_PRESENTED: begin
          frames_shown++;
          top_fence = out_fence_out;
        end
        ST_RETIRED: begin
          retires_done++;
          retire_floor = retire_req;
        end
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 5000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic drain();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send(input logic [2:0] act, input logic [3:0] slot, input logic [31:0] ser,
                      input logic [7:0] dmg, input logic full, input logic [31:0] fen,
                      input logic flag);
    drain();
    if (!quiet && $urandom_range(2) == 0) repeat ($urandom_range(1, 10)) @(posedge clk);
    in_action <= act;
    in_slot_index <= slot;
    in_image_serial <= ser;
    in_damage_count <= dmg;
    in_full_redraw <= full;
    in_completed_fence <= fen;
    in_flag_value <= flag;
    in_valid <= 1;
    if (act == ACT_RETIRE) retire_req = fen;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    in_valid <= 0;
    items_sent++;
  endtask

  task automatic present_ticket(input logic [7:0] dmg, input logic full);
    logic [3:0] s;
    logic [31:0] q;
    drain();
    if (ticket_slot.size() != 0) begin
      s = ticket_slot.pop_front();
      q = ticket_serial.pop_front();
    end else begin
      s = 4'($urandom_range(15));
      q = $urandom;
    end
    send(ACT_PRESENT, s, q, dmg, full, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic retire_some();
    logic [31:0] f;
    drain();
    f = (top_fence > retire_floor) ? retire_floor + $urandom_range(top_fence - retire_floor)
                                   : top_fence;
    send(ACT_RETIRE, 4'($urandom_range(15)), $urandom, 8'($urandom), 1'($urandom_range(1)),
         f, 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [3:0] imgs, input logic [3:0] mf, input logic [6:0] md,
                             input logic [30:0] bpi, input logic [31:0] bud);
    drain();
    repeat (20) @(posedge clk);
    write_reg(REG_IMAGE_COUNT, imgs);
    write_reg(REG_MAX_FLIGHT, mf);
    write_reg(REG_MAX_DAMAGE, md);
    write_reg(REG_BYTES_PER_IMAGE, bpi);
    write_reg(REG_BYTE_BUDGET, bud);
    settings_run++;
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30)
      send(ACT_ACQUIRE, 4'($urandom), $urandom, 8'($urandom), 1'($urandom), $urandom,
           1'($urandom));
    else if (pick < 55) present_ticket(8'($urandom_range(1, 8)), 1'($urandom_range(1)));
    else if (pick < 60) present_ticket(($urandom_range(1) ? 8'd0 : 8'(255 - $urandom_range(200))),
                                       1'($urandom_range(1)));
    else if (pick < 64)
      send(ACT_PRESENT, 4'($urandom), $urandom, 8'($urandom), 1'($urandom), 0, 0);
    else if (pick < 82) retire_some();
    else if (pick < 85) send(ACT_RETIRE, 0, 0, 0, 0, $urandom, 0);
    else if (pick < 89) send(ACT_SET_OCC, 0, 0, 0, 0, 0, $urandom_range(3) == 0);
    else if (pick < 92) send(ACT_SET_LOST, 0, 0, 0, 0, 0, $urandom_range(3) == 0);
    else if (pick < 94) send(ACT_MARK_OOD, 0, 0, 0, 0, 0, 0);
    else if (pick < 99) send(ACT_RECREATE, 0, 0, 0, 0, 0, 0);
    else
      send(ACT_UNUSED, 4'($urandom), $urandom, 8'($urandom), 1'($urandom), $urandom,
           1'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed, reset settings
    send(ACT_ACQUIRE, 0, 0, 0, 0, 0, 0);
    send(ACT_ACQUIRE, 0, 0, 0, 0, 0, 0);
    send(ACT_ACQUIRE, 0, 0, 0, 0, 0, 0);
    send(ACT_PRESENT, 4'd15, 32'hFFFF_FFFF, 8'd1, 1, 0, 0);
    send(ACT_PRESENT, 4'd0, 32'hDEAD_BEEF, 8'd1, 0, 0, 0);
    present_ticket(8'd33, 0);
    present_ticket(8'd0, 0);
    present_ticket(8'd0, 1);
    send(ACT_ACQUIRE, 0, 0, 0, 0, 0, 0);
    present_ticket(8'd32, 0);
    send(ACT_RETIRE, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
    send(ACT_RETIRE, 0, 0, 0, 0, 32'd1, 0);
    send(ACT_RETIRE, 0, 0, 0, 0, 32'd0, 0);
    send(ACT_RETIRE, 0, 0, 0, 0, 32'd2, 0);
    send(ACT_RECREATE, 0, 0, 0, 0, 0, 0);
    send(ACT_SET_OCC, 0, 0, 0, 0, 0, 1);
    send(ACT_ACQUIRE, 0, 0, 0, 0, 0, 0);
    send(ACT_SET_LOST, 0, 0, 0, 0, 0, 1);
    send(ACT_ACQUIRE, 0, 0, 0, 0, 0, 0);
    send(ACT_SET_LOST, 0, 0, 0, 0, 0, 0);
    send(ACT_MARK_OOD, 0, 0, 0, 0, 0, 0);
    send(ACT_ACQUIRE, 0, 0, 0, 0, 0, 0);
    send(ACT_RECREATE, 0, 0, 0, 0, 0, 0);
    send(ACT_UNUSED, 4'd15, 0, 8'd255, 1, 0, 1);
    ticket_slot.delete();
    ticket_serial.delete();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: reconfigure(3, 2, 32, 31'd4194304, 32'd134217728);
        1: reconfigure(8, 8, 64, 31'd1073741824, 32'hFFFF_FFFF);
        2: reconfigure(1, 1, 1, 31'd0, 32'd0);
        3: reconfigure(0, 4, 10, 31'd100, 32'd1000);
        4: reconfigure(8, 3, 5, 31'd1000, 32'd2500);
        5: reconfigure(15, 15, 127, 31'h7FFF_FFFF, 32'h8000_0000);
        6: reconfigure(5, 4, 64, 31'd4096, 32'd12288);
        default: reconfigure(8, 6, 40, 31'd65536, 32'd400000);
      endcase
      if (ph == 7) quiet = 1;
      repeat (ph == 3 ? 40 : 135) random_item();
      send(ACT_MARK_OOD, 0, 0, 0, 0, 0, 0);
      send(ACT_SET_OCC, 0, 0, 0, 0, 0, 0);
      send(ACT_SET_LOST, 0, 0, 0, 0, 0, 0);
    end

    drain();
    repeat (30) @(posedge clk);
    $display("Sent %0d items over %0d register settings plus reset defaults;", items_sent,
             settings_run);
    $display("%0d frames presented, %0d retires accepted.", frames_shown, retires_done);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

/* swapchain_image_slot_manager.f */
rtl/core/scim_pkg.sv
rtl/core/swapchain_image_slot_manager.sv
sim/swapchain_image_slot_manager_checker.sv
sim/swapchain_image_slot_manager_tb.sv
